### hw/rtl/ftc_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ftc_pkg: fan thermostat controller shared definitions
// Beat layouts, configuration set, mode and LED codes and the window timer
// step used by the controller engine.
// -----------------------------------------------------------------------------
package ftc_pkg;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_ADDR_W-1:0] CSR_STAND_TYPE     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FAN_TYPE       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HIGH_THRESHOLD = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOW_THRESHOLD  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_FAIL_TIMEOUT   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEST_WINDOW    = 3'd5;

   // Register reset values
   localparam logic       RST_STAND_TYPE     = 1'b0;
   localparam logic       RST_FAN_TYPE       = 1'b1;
   localparam logic [9:0] RST_HIGH_THRESHOLD = 10'd509;
   localparam logic [9:0] RST_LOW_THRESHOLD  = 10'd465;
   localparam logic [7:0] RST_FAIL_TIMEOUT   = 8'd40;
   localparam logic [7:0] RST_TEST_WINDOW    = 8'd50;

   // Stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_BITS   = 11;

   // Mode codes as reported on the result beat
   localparam logic [2:0] MODE_INIT    = 3'd0;
   localparam logic [2:0] MODE_WAIT_SW = 3'd1;
   localparam logic [2:0] MODE_DIAG    = 3'd2;
   localparam logic [2:0] MODE_HEAT    = 3'd3;
   localparam logic [2:0] MODE_COOL    = 3'd4;

   localparam int ELAPSED_W = 9;

   typedef enum logic [4:0] {
      ST_INIT    = 5'b00001,
      ST_WAIT_SW = 5'b00010,
      ST_DIAG    = 5'b00100,
      ST_HEAT    = 5'b01000,
      ST_COOL    = 5'b10000
   } mode_state_type;

   typedef enum logic [1:0] {
      LM_ON    = 2'd0,
      LM_OFF   = 2'd1,
      LM_BLINK = 2'd2
   } led_mode_type;

   typedef struct packed {
      logic       stand_type;
      logic       fan_type;
      logic [9:0] high_threshold;
      logic [9:0] low_threshold;
      logic [7:0] fail_timeout;
      logic [7:0] test_window;
   } cfg_type;

   // Request beat, last field first so temperature lands in the low bits
   typedef struct packed {
      logic       fan2_pulse;
      logic       fan1_pulse;
      logic       fan2_level;
      logic       fan1_level;
      logic       start_switch;
      logic [9:0] temperature;
   } item_type;

   // Result beat, fan1_on in bit 0
   typedef struct packed {
      logic [2:0] mode_now;
      logic       fan2_failed;
      logic       fan1_failed;
      logic       led_alarm2;
      logic       led_alarm1;
      logic       led_normal2;
      logic       led_normal1;
      logic       fan2_on;
      logic       fan1_on;
   } result_type;

   typedef struct packed {
      logic [ELAPSED_W-1:0] elapsed;
      logic                 idle;
   } timer_type;

   // One step of the window timer: start from idle, else count to the end
   function automatic timer_type timer_step(logic [ELAPSED_W-1:0] elapsed,
                                            logic idle,
                                            logic [ELAPSED_W-1:0] end_v);
      timer_type t;
      if (idle) begin
         t.elapsed = '0;
         t.idle    = 1'b0;
      end else begin
         t.elapsed = elapsed + ELAPSED_W'(1);
         t.idle    = (t.elapsed == end_v);
      end
      return t;
   endfunction

   function automatic logic [2:0] mode_code(mode_state_type m);
      logic [2:0] c;
      unique case (m)
         ST_WAIT_SW: c = MODE_WAIT_SW;
         ST_DIAG:    c = MODE_DIAG;
         ST_HEAT:    c = MODE_HEAT;
         ST_COOL:    c = MODE_COOL;
         default:    c = MODE_INIT;
      endcase
      return c;
   endfunction

endpackage

### hw/rtl/ftc_csr.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ftc_csr: configuration registers
// Holds the six control registers, written through a plain write port.
// -----------------------------------------------------------------------------
module ftc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ftc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ftc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output ftc_pkg::cfg_type                    cfg
);

   ftc_pkg::cfg_type cfg_ff;

   // Write the addressed register, ignore unused indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stand_type     <= ftc_pkg::RST_STAND_TYPE;
         cfg_ff.fan_type       <= ftc_pkg::RST_FAN_TYPE;
         cfg_ff.high_threshold <= ftc_pkg::RST_HIGH_THRESHOLD;
         cfg_ff.low_threshold  <= ftc_pkg::RST_LOW_THRESHOLD;
         cfg_ff.fail_timeout   <= ftc_pkg::RST_FAIL_TIMEOUT;
         cfg_ff.test_window    <= ftc_pkg::RST_TEST_WINDOW;
      end else if (csr_we) begin
         unique case (csr_addr)
            ftc_pkg::CSR_STAND_TYPE:     cfg_ff.stand_type     <= csr_wdata[0];
            ftc_pkg::CSR_FAN_TYPE:       cfg_ff.fan_type       <= csr_wdata[0];
            ftc_pkg::CSR_HIGH_THRESHOLD: cfg_ff.high_threshold <= csr_wdata[9:0];
            ftc_pkg::CSR_LOW_THRESHOLD:  cfg_ff.low_threshold  <= csr_wdata[9:0];
            ftc_pkg::CSR_FAIL_TIMEOUT:   cfg_ff.fail_timeout   <= csr_wdata[7:0];
            ftc_pkg::CSR_TEST_WINDOW:    cfg_ff.test_window    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/ftc_engine.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ftc_engine: per-tick controller state and next-state logic
// Blink phase, fan failure countdowns, window timer and the mode machine.
// The result presented is the state after the tick being stepped.
// -----------------------------------------------------------------------------
module ftc_engine #(
   parameter int TICKS_PER_SECOND = 10,
   parameter int INIT_TICKS       = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  ftc_pkg::cfg_type     cfg,
   input  ftc_pkg::item_type    item,
   output ftc_pkg::result_type  result
);

   localparam int PHASE_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
   localparam int EW      = ftc_pkg::ELAPSED_W;

   ftc_pkg::mode_state_type mode_ff, mode_in;
   logic [EW-1:0]           elapsed_ff, elapsed_in;
   logic                    idle_ff, idle_in;
   logic [7:0]              cnt_ff [2];
   logic [7:0]              cnt_in [2];
   logic [1:0]              fail_ff, fail_in;
   logic [1:0]              drive_ff, drive_in;
   ftc_pkg::led_mode_type   led_mode_ff [4];
   ftc_pkg::led_mode_type   led_mode_in [4];
   logic [3:0]              led_level_ff, led_level_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [PHASE_W:0]        phase_inc;

   logic [1:0]              rep_en;
   logic                    rep_blink;
   logic                    force_n2;
   logic [1:0]              fb_level, fb_pulse;
   logic [EW-1:0]           win, win2;

   assign fb_level  = {item.fan2_level, item.fan1_level};
   assign fb_pulse  = {item.fan2_pulse, item.fan1_pulse};
   assign win       = {1'b0, cfg.test_window};
   assign win2      = {cfg.test_window, 1'b0};
   assign phase_inc = {1'b0, phase_ff} + (PHASE_W+1)'(1);

   // Next state for one tick
   always_comb begin
      mode_in      = mode_ff;
      elapsed_in   = elapsed_ff;
      idle_in      = idle_ff;
      fail_in      = fail_ff;
      drive_in     = drive_ff;
      led_level_in = led_level_ff;
      for (int i = 0; i < 4; i++) led_mode_in[i] = led_mode_ff[i];
      for (int f = 0; f < 2; f++) cnt_in[f] = cnt_ff[f];
      rep_en    = 2'b00;
      rep_blink = 1'b0;
      force_n2  = 1'b0;

      // Toggle blinking normal LEDs once a second, keep the pair in step
      if (phase_ff == '0) begin
         for (int i = 0; i < 2; i++) begin
            if (led_mode_ff[i] == ftc_pkg::LM_BLINK) led_level_in[i] = ~led_level_ff[i];
         end
         if (led_mode_ff[0] == ftc_pkg::LM_BLINK && led_mode_ff[1] == ftc_pkg::LM_BLINK &&
             !led_level_in[0] && led_level_in[1]) begin
            led_level_in[0] = 1'b1;
         end
      end
      phase_in = (phase_inc >= (PHASE_W+1)'(TICKS_PER_SECOND)) ? '0 : phase_inc[PHASE_W-1:0];

      // Fan feedback countdowns
      for (int f = 0; f < 2; f++) begin
         if (!cfg.fan_type && fb_pulse[f]) cnt_in[f] = cfg.fail_timeout;
         if (drive_ff[f]) begin
            if (cnt_in[f] != 8'd0) cnt_in[f] = cnt_in[f] - 8'd1;
            if (cfg.fan_type && fb_level[f]) cnt_in[f] = cfg.fail_timeout;
            fail_in[f] = (cnt_in[f] == 8'd0);
         end
      end

      // Mode machine
      unique case (mode_ff)
         ftc_pkg::ST_WAIT_SW: begin
            for (int i = 0; i < 4; i++) led_mode_in[i] = ftc_pkg::LM_OFF;
            led_level_in = 4'b0000;
            if (item.start_switch) mode_in = ftc_pkg::ST_DIAG;
         end
         ftc_pkg::ST_DIAG: begin
            if (!cfg.stand_type) begin
               {elapsed_in, idle_in} = ftc_pkg::timer_step(elapsed_ff, idle_ff, win);
               drive_in = 2'b11;
               led_mode_in[0] = ftc_pkg::LM_BLINK;
               led_mode_in[1] = ftc_pkg::LM_BLINK;
               led_mode_in[2] = ftc_pkg::LM_ON;
               led_mode_in[3] = ftc_pkg::LM_ON;
               led_level_in[3:2] = 2'b11;
               if (idle_in) begin
                  drive_in = 2'b00;
                  rep_en   = 2'b11;
                  mode_in  = ftc_pkg::ST_HEAT;
               end
            end else begin
               {elapsed_in, idle_in} = ftc_pkg::timer_step(elapsed_ff, idle_ff, win2);
               if (elapsed_in < win) begin
                  drive_in = 2'b01;
                  led_mode_in[0] = ftc_pkg::LM_BLINK;
                  for (int i = 1; i < 4; i++) led_mode_in[i] = ftc_pkg::LM_OFF;
                  led_level_in[3:1] = 3'b000;
               end else if (elapsed_in == win) begin
                  rep_en[0] = 1'b1;
               end else begin
                  drive_in = 2'b10;
                  led_mode_in[1] = ftc_pkg::LM_BLINK;
                  led_mode_in[3] = ftc_pkg::LM_ON;
                  led_level_in[3] = 1'b1;
                  if (idle_in) begin
                     drive_in[1] = 1'b0;
                     rep_en[1]   = 1'b1;
                     mode_in     = ftc_pkg::ST_HEAT;
                  end
               end
            end
         end
         ftc_pkg::ST_HEAT: begin
            if (item.temperature < cfg.high_threshold) begin
               drive_in = 2'b00;
            end else if (!cfg.stand_type) begin
               {elapsed_in, idle_in} = ftc_pkg::timer_step(elapsed_ff, idle_ff, win);
               drive_in = 2'b11;
               if (idle_in) begin
                  rep_en    = 2'b11;
                  rep_blink = 1'b1;
                  if (!fail_in[0] || !fail_in[1]) mode_in = ftc_pkg::ST_COOL;
               end
            end else begin
               {elapsed_in, idle_in} = ftc_pkg::timer_step(elapsed_ff, idle_ff, win2);
               rep_blink = 1'b1;
               if (elapsed_in < win) begin
                  drive_in = 2'b01;
               end else if (elapsed_in == win) begin
                  rep_en[0] = 1'b1;
                  if (!fail_in[0]) mode_in = ftc_pkg::ST_COOL;
                  else             drive_in[0] = 1'b0;
               end else begin
                  drive_in[1] = 1'b1;
                  if (idle_in) begin
                     rep_en[1] = 1'b1;
                     if (!fail_in[1]) mode_in = ftc_pkg::ST_COOL;
                     else             drive_in[1] = 1'b0;
                  end
               end
            end
         end
         ftc_pkg::ST_COOL: begin
            if (item.temperature < cfg.low_threshold) begin
               rep_en  = 2'b11;
               idle_in = 1'b1;
               mode_in = ftc_pkg::ST_HEAT;
            end else if (!cfg.stand_type) begin
               drive_in  = 2'b11;
               rep_en    = 2'b11;
               rep_blink = 1'b1;
            end else begin
               {elapsed_in, idle_in} = ftc_pkg::timer_step(elapsed_ff, idle_ff, win);
               if (idle_in) begin
                  rep_en    = 2'b11;
                  rep_blink = 1'b1;
                  // Rotate duty towards the healthy fan, swap if both failed
                  if (!fail_in[0]) begin
                     drive_in = 2'b01;
                     force_n2 = !fail_in[1];
                  end else if (!fail_in[1]) begin
                     drive_in = 2'b10;
                  end else begin
                     drive_in = {drive_ff[0], ~drive_ff[0]};
                  end
               end
            end
         end
         default: begin
            // Init: all LEDs on for the start-up period
            for (int i = 0; i < 4; i++) led_mode_in[i] = ftc_pkg::LM_ON;
            led_level_in = 4'b1111;
            elapsed_in   = elapsed_ff + EW'(1);
            if (elapsed_in >= EW'(INIT_TICKS)) begin
               elapsed_in = '0;
               mode_in    = ftc_pkg::ST_WAIT_SW;
            end
         end
      endcase

      // Report fan health on the normal and alarm LEDs
      for (int f = 0; f < 2; f++) begin
         if (rep_en[f]) begin
            if (!fail_in[f]) begin
               if (rep_blink) begin
                  led_mode_in[f] = ftc_pkg::LM_BLINK;
               end else begin
                  led_mode_in[f]  = ftc_pkg::LM_ON;
                  led_level_in[f] = 1'b1;
               end
               led_mode_in[f+2]  = ftc_pkg::LM_OFF;
               led_level_in[f+2] = 1'b0;
            end else begin
               led_mode_in[f]    = ftc_pkg::LM_OFF;
               led_level_in[f]   = 1'b0;
               led_mode_in[f+2]  = ftc_pkg::LM_ON;
               led_level_in[f+2] = 1'b1;
            end
         end
      end
      if (force_n2) begin
         led_mode_in[1]  = ftc_pkg::LM_ON;
         led_level_in[1] = 1'b1;
      end
   end

   // Advance state on each stepped tick
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ftc_pkg::ST_INIT;
         elapsed_ff   <= '0;
         idle_ff      <= 1'b1;
         fail_ff      <= 2'b11;
         drive_ff     <= 2'b00;
         led_level_ff <= 4'b0000;
         phase_ff     <= '0;
         for (int f = 0; f < 2; f++) cnt_ff[f] <= 8'd0;
         for (int i = 0; i < 4; i++) led_mode_ff[i] <= ftc_pkg::LM_ON;
      end else if (step_en) begin
         mode_ff      <= mode_in;
         elapsed_ff   <= elapsed_in;
         idle_ff      <= idle_in;
         fail_ff      <= fail_in;
         drive_ff     <= drive_in;
         led_level_ff <= led_level_in;
         phase_ff     <= phase_in;
         for (int f = 0; f < 2; f++) cnt_ff[f] <= cnt_in[f];
         for (int i = 0; i < 4; i++) led_mode_ff[i] <= led_mode_in[i];
      end
   end

   // Result of this tick
   always_comb begin
      result.fan1_on     = drive_in[0];
      result.fan2_on     = drive_in[1];
      result.led_normal1 = led_level_in[0];
      result.led_normal2 = led_level_in[1];
      result.led_alarm1  = led_level_in[2];
      result.led_alarm2  = led_level_in[3];
      result.fan1_failed = fail_in[0];
      result.fan2_failed = fail_in[1];
      result.mode_now    = ftc_pkg::mode_code(mode_in);
   end

   // Hold state between ticks
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(mode_ff) && $stable(elapsed_ff))
      else $error("controller state moved without a tick");

   // Start-up count never reaches its end while still in init
   a_init_count: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ftc_pkg::ST_INIT |-> elapsed_ff < EW'(INIT_TICKS))
      else $error("init count overran");

   // An undriven fan keeps its failure status
   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      step_en && !drive_ff[0] |=> fail_ff[0] == $past(fail_ff[0]))
      else $error("fan 1 status changed while not driven");

endmodule

### hw/rtl/fan_thermostat_controller_core.sv
`timescale 1ns / 1ps
// Flow: a request beat is captured in the request register; when the engine steps
// it, the result register is loaded and the result beat is offered from it.
// Throughput: one tick per cycle; the engine steps whenever a beat waits and the result
// register is empty or being drained, so the pipeline never bubbles.
// Reset: synchronous, active high; configuration, valid flag and engine registers
// return to defaults; the mode machine restarts in init with both fans marked failed.
// -----------------------------------------------------------------------------
// fan_thermostat_controller_core: fan thermostat controller top level
// Request register, controller engine, result register and configuration.
// -----------------------------------------------------------------------------
module fan_thermostat_controller_core #(
   parameter int TICKS_PER_SECOND = 10,
   parameter int INIT_TICKS       = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request: temperature[9:0], start_switch, fan1_level, fan2_level,
   // fan1_pulse, fan2_pulse
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ftc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Result: fan1_on, fan2_on, led_normal1, led_normal2, led_alarm1,
   // led_alarm2, fan1_failed, fan2_failed, mode_now[2:0], zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ftc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [ftc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ftc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ftc_pkg::cfg_type    cfg;
   ftc_pkg::item_type   item_ff;
   ftc_pkg::result_type res_next;
   ftc_pkg::result_type res_ff;
   logic                in_valid_ff;
   logic                out_valid_ff;
   logic                advance;

   ftc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Step the engine when a beat waits and the result slot is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ftc_engine #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND),
      .INIT_TICKS       (INIT_TICKS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cfg     (cfg),
      .item    (item_ff),
      .result  (res_next)
   );

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance)         out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   // Capture request and result beats
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= ftc_pkg::item_type'(req_tdata[$bits(ftc_pkg::item_type)-1:0]);
      end
      if (advance)                  res_ff  <= res_next;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(ftc_pkg::RSP_DATA_W - ftc_pkg::RSP_BITS){1'b0}}, res_ff};

   // Requests back up only when both stages are full and the result stalls
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("request side stalled without a full pipeline");

   // Every engine step presents a result beat
   a_step_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("stepped tick produced no result beat");

   // Hold the result beat while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

endmodule
